FILE: rtl/rpkp_pkg.sv
// package: action and status codes, item types and state machine type for the key pool
package rpkp_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_PICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DIVIDE,
    S_READ,
    S_MOVE,
    S_OUT
  } fsm_t;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned RND_W   = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [RND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   picked_key;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

FILE: rtl/rpkp_if.sv
// valid/ready channel interface carrying a generic payload
interface rpkp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/random_pick_key_pool.sv
// random pick key pool: dense key set with insert, delete and random pick
//
// Channels: in (action, key, random_value) and out (status, picked_key,
// count), both valid/ready. One result item per input item.
// Keys sit in positions 0..count-1 of a single-port-read key memory.
// Insert and delete scan the memory one position per cycle to find the
// key; a delete then copies the last key into the hole, reading it in
// S_READ and writing it in S_MOVE. A pick runs a bit-serial remainder of
// random_value by count and one memory read. One item at a time; the scan
// through the memory port and the remainder unit set the time per item.
// Reset clears the count and control; the memory needs no clearing since
// only positions below the count are read.
// The result waits in an output register; while the receiver stalls no new
// item is accepted, the next one is taken the cycle after the result leaves.
module random_pick_key_pool
  import rpkp_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rpkp_if.sink       in_ch,
  rpkp_if.source     out_ch
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  fsm_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    hole_r, hole_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic [CW-1:0]    ridx_r, ridx_nxt;
  logic             ovalid_r, ovalid_nxt;
  status_t          ostat_r, ostat_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;
  logic             div_start, div_done;
  logic [CW-1:0]    div_rem;

  rpkp_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // the remainder unit latches its dividend with start, so it takes the incoming value
  rpkp_mod #(.CW(CW)) u_mod (
    .clk, .rst_n, .start(div_start), .dividend(rnd_nxt), .divisor(count_r),
    .done(div_done), .remainder(div_rem)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload.status = ostat_r;
  assign out_ch.payload.picked_key = okey_r;
  assign out_ch.payload.count = COUNT_W'(count_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    hole_nxt   = hole_r;
    act_nxt    = act_r;
    key_nxt    = key_r;
    rnd_nxt    = rnd_r;
    rvalid_nxt = 1'b0;
    ridx_nxt   = ridx_r;
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    okey_nxt   = okey_r;
    we         = 1'b0;
    waddr      = hole_r;
    wdata      = rdata;
    raddr      = idx_r[AW-1:0];
    div_start  = 1'b0;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !ovalid_r) begin
          act_nxt = in_ch.payload.action;
          key_nxt = in_ch.payload.key;
          rnd_nxt = in_ch.payload.random_value;
          idx_nxt = '0;
          okey_nxt = '0;
          ostat_nxt = ST_OK;
          case (action_t'(in_ch.payload.action))
            ACT_INSERT, ACT_DELETE: state_nxt = S_SEARCH;
            ACT_PICK: begin
              if (count_r == '0) begin
                ostat_nxt = ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_DIVIDE;
                div_start = 1'b1;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SEARCH: begin
        // issue read at idx_r, compare the read of the previous cycle
        if (rvalid_r && rdata == key_r) begin
          hole_nxt = ridx_r[AW-1:0];
          if (act_r == ACT_INSERT) begin
            ostat_nxt = ST_DUPLICATE;
            state_nxt = S_OUT;
          end else begin
            idx_nxt = count_r - CW'(1);
            state_nxt = S_READ;
          end
        end else if (idx_r < count_r) begin
          rvalid_nxt = 1'b1;
          ridx_nxt = idx_r;
          idx_nxt = idx_r + CW'(1);
        end else if (!rvalid_r) begin
          state_nxt = S_OUT;
          if (act_r == ACT_DELETE) ostat_nxt = ST_NOT_FOUND;
          else if (count_r >= CW'(CAPACITY)) ostat_nxt = ST_FULL;
          else begin
            we = 1'b1;
            waddr = count_r[AW-1:0];
            wdata = key_r;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          idx_nxt = div_rem;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MOVE;
      S_MOVE: begin
        state_nxt = S_OUT;
        if (act_r == ACT_PICK) okey_nxt = rdata;
        else begin
          we = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      rvalid_r <= rvalid_nxt;
    end
    idx_r   <= idx_nxt;
    ridx_r  <= ridx_nxt;
    hole_r  <= hole_nxt;
    act_r   <= act_nxt;
    key_r   <= key_nxt;
    rnd_r   <= rnd_nxt;
    ostat_r <= ostat_nxt;
    okey_r  <= okey_nxt;
  end
endmodule

FILE: rtl/rpkp_mod.sv
// restoring remainder unit: one quotient bit per cycle
module rpkp_mod
  import rpkp_pkg::*;
#(
  parameter int unsigned CW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             done,
  output logic [CW-1:0]    remainder
);
  localparam int unsigned SW = $clog2(RND_W + 1);

  logic [RND_W-1:0] num_r, num_nxt;
  logic [CW:0]      rem_r, rem_nxt;
  logic [SW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW:0]      trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CW-1:0], num_r[RND_W-1]};
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = SW'(RND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem_nxt = trial - {1'b0, divisor};
      else rem_nxt = trial;
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[CW-1:0];
endmodule

FILE: rtl/rpkp_store.sv
// key memory: one write port, one registered read port
module rpkp_store
  import rpkp_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);
  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
